[rtl/core/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg
// shared types and constants of the frame bitmap allocator
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int FRAME_W     = 12;
  localparam int FC_W        = 13;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int FIELD_WORDS = 128;

  localparam logic [FC_W-1:0]   FC_RESET  = 13'd4096;
  localparam logic [WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOOP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic               command;
    logic [FRAME_W-1:0] page_frame;
    logic               kernel_page;
    logic               writeable;
  } in_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               present_bit;
    logic               write_bit;
    logic               user_bit;
    logic [1:0]         status;
  } out_rsp_t;

endpackage

[rtl/core/frame_bitmap_allocator_core.sv]
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// physical page-frame allocator over a used/free bitmap in one memory
// ----------------------------------------------------------------------------
// requests arrive on in_valid/in_ready with an in_req_t payload; each request
// gives exactly one result on out_valid/out_ready as an out_rsp_t.
// an allocate request with page_frame 0 scans whole bitmap words below
// cfg frame_count from word 0 up, one memory read per cycle, and takes the
// lowest clear bit. a free request clears the bit of its frame.
// the path from accept to out_valid: a no-op or a request that needs no memory
// access goes through S_WAIT, a free through S_FREE and then S_WAIT, and an
// allocation through S_SCAN, while it reads words, and then S_WAIT.
// one request is in flight at a time; the scan loop over the single-port
// read of the bitmap memory sets the rate. in_ready is high while idle,
// also while a finished result waits in the output register.
// reset marks every bitmap word free through per-word valid bits, so the
// block is ready in the first cycle after reset; frame_count resets to 4096.
// a stalled receiver holds the result; the next result waits behind it.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core
  import fba_pkg::*;
#(
  parameter int NFRAMES = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_req_t         in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output out_rsp_t        out_rsp,
  input  logic            cfg_we,
  input  logic [FC_W-1:0] cfg_wdata
);

  localparam int WORDS = NFRAMES / WORD_W;
  localparam int DEPTH = (WORDS < FIELD_WORDS) ? WORDS : FIELD_WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FREE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [7:0]        limit_r, limit_nxt;
  in_req_t           req_r, req_nxt;
  out_rsp_t          res_r, res_nxt;
  out_rsp_t          out_r;
  logic              out_valid_r;
  logic [FC_W-1:0]   frame_count_r;
  logic [DEPTH-1:0]  vld_r;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [WORD_W-1:0] wdata;

  logic [WORD_W-1:0] word_cur;
  logic [BIT_W-1:0]  zpos;
  logic [6:0]        fword;
  logic [7:0]        fc_words;
  logic [7:0]        lim_eff;

  assign word_cur = vld_r[idx_r] ? rdata_r : '0;
  assign fword    = in_req.page_frame[FRAME_W-1:BIT_W];
  assign fc_words = frame_count_r[FC_W-1:BIT_W];
  assign lim_eff  = (fc_words > 8'(DEPTH)) ? 8'(DEPTH) : fc_words;

  fba_zero_find u_zero_find (
    .word (word_cur),
    .pos  (zpos)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    limit_nxt = limit_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    raddr     = idx_r;
    mem_we    = 1'b0;
    wdata     = word_cur;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          res_nxt = '{frame_out: '0, present_bit: 1'b0, write_bit: 1'b0,
                      user_bit: 1'b0, status: ST_DONE};
          if (in_req.command == CMD_FREE) begin
            if (in_req.page_frame == '0) begin
              res_nxt.status = ST_NOOP;
              state_nxt      = S_WAIT;
            end else if ({1'b0, fword} < 8'(DEPTH)) begin
              raddr     = fword[AW-1:0];
              idx_nxt   = fword[AW-1:0];
              state_nxt = S_FREE;
            end else begin
              state_nxt = S_WAIT;
            end
          end else begin
            if (in_req.page_frame != '0) begin
              res_nxt.frame_out = in_req.page_frame;
              res_nxt.status    = ST_NOOP;
              state_nxt         = S_WAIT;
            end else if (lim_eff == '0) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_WAIT;
            end else begin
              raddr     = '0;
              idx_nxt   = '0;
              limit_nxt = lim_eff;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_FREE: begin
        mem_we    = 1'b1;
        wdata     = word_cur & ~(WORD_W'(1) << req_r.page_frame[BIT_W-1:0]);
        state_nxt = S_WAIT;
      end
      S_SCAN: begin
        if (word_cur != FULL_WORD) begin
          mem_we              = 1'b1;
          wdata               = word_cur | (WORD_W'(1) << zpos);
          res_nxt.frame_out   = FRAME_W'({idx_r, zpos});
          res_nxt.present_bit = 1'b1;
          res_nxt.write_bit   = req_r.writeable;
          res_nxt.user_bit    = ~req_r.kernel_page;
          res_nxt.status      = ST_DONE;
          state_nxt           = S_WAIT;
        end else if (8'(idx_r) + 8'd1 < limit_r) begin
          idx_nxt = idx_r + AW'(1);
          raddr   = idx_nxt;
        end else begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      vld_r         <= '0;
      frame_count_r <= FC_RESET;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
      if (state_r == S_WAIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    limit_r <= limit_nxt;
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    if (state_r == S_WAIT && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

[rtl/core/fba_zero_find.sv]
// ----------------------------------------------------------------------------
// fba_zero_find
// position of the lowest clear bit of a bitmap word
// ----------------------------------------------------------------------------
module fba_zero_find
  import fba_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  output logic [BIT_W-1:0]  pos
);

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

endmodule

[tb/frame_bitmap_allocator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core_tb
// self-checking bench for the bitmap page-frame allocator
// ----------------------------------------------------------------------------
// keeps its own copy of the used bitmap and frame count, predicts the result
// of every accepted request and checks each result in order, field by field.
// directed cases cover frame zero, no-ops, frees of clear and high frames,
// frame counts of 0, 31 and 8191 and a small bitmap run until full; random
// phases with sender and receiver gaps, and a long receiver hold-off, follow.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core_tb;
  import fba_pkg::*;

  localparam int MAP_WORDS   = 4096 / WORD_W;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 150;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_req_t         in_req;
  logic            out_valid;
  logic            out_ready;
  out_rsp_t        out_rsp;
  logic            cfg_we;
  logic [FC_W-1:0] cfg_wdata;

  logic [WORD_W-1:0]  used_map [MAP_WORDS];
  logic [FC_W-1:0]    frames_managed;
  out_rsp_t           pending_rsp [$];
  logic [FRAME_W-1:0] held_frames [$];
  out_rsp_t           want_rsp;

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int stall_cycles;
  int errors;
  int n_requests;
  int n_granted;
  int n_full;
  int n_noop;
  int n_freed;

  frame_bitmap_allocator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 30) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic out_rsp_t predict_frame_rsp(input in_req_t req);
    out_rsp_t           rsp;
    int                 limit;
    int                 w;
    int                 b;
    logic               found;
    logic [FRAME_W-1:0] frame;
    rsp = '0;
    if (req.command == CMD_FREE) begin
      if (req.page_frame == '0) begin
        rsp.status = ST_NOOP;
        n_noop++;
      end else begin
        used_map[req.page_frame[FRAME_W-1:BIT_W]][req.page_frame[BIT_W-1:0]] = 1'b0;
        rsp.status = ST_DONE;
        n_freed++;
      end
    end else if (req.page_frame != '0) begin
      rsp.frame_out = req.page_frame;
      rsp.status    = ST_NOOP;
      n_noop++;
    end else begin
      limit = int'(frames_managed >> BIT_W);
      if (limit > MAP_WORDS) limit = MAP_WORDS;
      if (limit > FIELD_WORDS) limit = FIELD_WORDS;
      found = 1'b0;
      for (w = 0; w < limit && !found; w++) begin
        if (used_map[w] != FULL_WORD) begin
          b = 0;
          while (b < WORD_W - 1 && used_map[w][b]) b++;
          used_map[w][b]  = 1'b1;
          frame           = FRAME_W'(w * WORD_W + b);
          rsp.frame_out   = frame;
          rsp.present_bit = 1'b1;
          rsp.write_bit   = req.writeable;
          rsp.user_bit    = ~req.kernel_page;
          rsp.status      = ST_DONE;
          found           = 1'b1;
          if (frame != '0) held_frames.push_back(frame);
        end
      end
      if (found) begin
        n_granted++;
      end else begin
        rsp.status = ST_FULL;
        n_full++;
      end
    end
    return rsp;
  endfunction

  function automatic in_req_t make_req(input logic cmd, input logic [FRAME_W-1:0] pf,
                                       input logic kern, input logic wr);
    in_req_t req;
    req.command     = cmd;
    req.page_frame  = pf;
    req.kernel_page = kern;
    req.writeable   = wr;
    return req;
  endfunction

  // mostly allocations and frees of held frames, the rest no-ops and stray frees
  function automatic in_req_t random_request(input int free_pct);
    in_req_t     req;
    int unsigned pick;
    int          idx;
    req = make_req(CMD_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < free_pct && held_frames.size() > 0) begin
      idx = $urandom_range(0, held_frames.size() - 1);
      req.command    = CMD_FREE;
      req.page_frame = held_frames[idx];
      held_frames.delete(idx);
    end else if (pick >= 70 && pick < 78) begin
      req.page_frame = FRAME_W'($urandom_range(1, 4095));
    end else if (pick >= 78 && pick < 83) begin
      req.command = CMD_FREE;
    end else if (pick >= 83 && pick < 93) begin
      req.command    = CMD_FREE;
      req.page_frame = FRAME_W'($urandom_range(1, 4095));
    end
    return req;
  endfunction

  task automatic send_request(input in_req_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(predict_frame_rsp(req));
    n_requests++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [FC_W-1:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    frames_managed = value;
  endtask

  task automatic test_directed_cases();
    tx_idle_pct = 10;
    rx_idle_pct = 67;
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b1));
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b0));
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b0));
    send_request(make_req(CMD_ALLOC, 12'hFFF, 1'b1, 1'b1));
    send_request(make_req(CMD_ALLOC, 12'h800, 1'b0, 1'b0));
    send_request(make_req(CMD_FREE, '0, 1'b1, 1'b1));
    send_request(make_req(CMD_FREE, 12'd1, 1'b0, 1'b0));
    send_request(make_req(CMD_FREE, 12'hFFF, 1'b1, 1'b0));
    send_request(make_req(CMD_FREE, 12'd2, 1'b0, 1'b1));
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b1));
    set_frame_count('0);
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b1));
    set_frame_count(13'd31);
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b0));
    send_request(make_req(CMD_FREE, 12'd1, 1'b0, 1'b0));
    set_frame_count(13'h1FFF);
    send_request(make_req(CMD_ALLOC, '0, 1'b0, 1'b0));
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b1));
    set_frame_count(FC_RESET);
  endtask

  task automatic test_exhaust_small_count();
    set_frame_count(13'd32);
    repeat (31) send_request(make_req(CMD_ALLOC, '0, 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))));
    send_request(make_req(CMD_FREE, 12'd17, 1'b0, 1'b0));
    send_request(make_req(CMD_FREE, 12'd31, 1'b1, 1'b1));
    repeat (3) send_request(make_req(CMD_ALLOC, '0, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1))));
    set_frame_count(13'd64);
    send_request(make_req(CMD_ALLOC, '0, 1'b1, 1'b0));
  endtask

  task automatic test_random_phase(input int count, input int tx_pct, input int rx_pct,
                                   input logic [FC_W-1:0] fc, input int free_pct);
    set_frame_count(fc);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_request(random_request(free_pct));
  endtask

  task automatic test_output_backpressure();
    wait_for_drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(posedge clk);
    rx_hold = 400;
    repeat (8) send_request(random_request(30));
  endtask

  // receiver: random gaps, or a counted hold-off when rx_hold is loaded
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected result frame %0d status %0d",
                                  out_rsp.frame_out, out_rsp.status));
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (out_rsp.frame_out !== want_rsp.frame_out)
          report_mismatch($sformatf("frame_out %0d, expected %0d",
                                    out_rsp.frame_out, want_rsp.frame_out));
        if (out_rsp.present_bit !== want_rsp.present_bit)
          report_mismatch($sformatf("present_bit %b, expected %b",
                                    out_rsp.present_bit, want_rsp.present_bit));
        if (out_rsp.write_bit !== want_rsp.write_bit)
          report_mismatch($sformatf("write_bit %b, expected %b",
                                    out_rsp.write_bit, want_rsp.write_bit));
        if (out_rsp.user_bit !== want_rsp.user_bit)
          report_mismatch($sformatf("user_bit %b, expected %b",
                                    out_rsp.user_bit, want_rsp.user_bit));
        if (out_rsp.status !== want_rsp.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_rsp.status, want_rsp.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no request or result moved for %0d cycles", $realtime, stall_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = FC_RESET;
    for (int i = 0; i < MAP_WORDS; i++) used_map[i] = '0;
    frames_managed = FC_RESET;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold      = 0;
    stall_cycles = 0;
    errors       = 0;
    n_requests   = 0;
    n_granted    = 0;
    n_full       = 0;
    n_noop       = 0;
    n_freed      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_exhaust_small_count();
    test_random_phase(160, 10, 67, FC_RESET, 30);
    test_random_phase(160, 67, 10, 13'd64, 15);
    test_output_backpressure();
    test_random_phase(160, 0, 0, FC_W'($urandom_range(128, 8191)), 25);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));
    end
    $display("%0d requests: %0d frames handed out, %0d full, %0d no-ops, %0d frees",
             n_requests, n_granted, n_full, n_noop, n_freed);
    $display("frame counts 0, 31, 32, 64, 4096, 8191 and random, with output hold-off");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/fba_pkg.sv
rtl/core/fba_zero_find.sv
rtl/core/frame_bitmap_allocator_core.sv
tb/frame_bitmap_allocator_core_tb.sv
